FILE: hdl/tli_pkg.sv
package tli_pkg;

  localparam int COORD_BITS = 16;
  localparam int VALUE_BITS = 16;
  localparam int FRAC_BITS  = 8;

  localparam int FIELD_BITS = 16;
  localparam int RES_BITS   = 32;
  localparam int CW = (COORD_BITS > FIELD_BITS) ? FIELD_BITS + 1 : COORD_BITS;
  localparam int VW = (VALUE_BITS > FIELD_BITS) ? FIELD_BITS + 1 : VALUE_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int EW = PW + 1;
  localparam int MW = EW + VW;
  localparam int SW = MW + 2;
  localparam int AW = SW + RES_BITS;
  localparam int HI_SHIFT = RES_BITS - FRAC_BITS;

  typedef enum logic [2:0] {
    REG_VERTEX_A = 3'd0,
    REG_VERTEX_B = 3'd1,
    REG_VERTEX_C = 3'd2,
    REG_VALUE_A  = 3'd3,
    REG_VALUE_B  = 3'd4,
    REG_VALUE_C  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] query_x;
    logic signed [FIELD_BITS-1:0] query_y;
  } in_t;

  typedef struct packed {
    logic signed [RES_BITS-1:0] interp_value;
    logic                       inside_res;
    logic                       degenerate;
    logic                       saturated;
  } out_t;

  typedef struct packed {
    logic [2:0][CW-1:0] ox;
    logic [2:0][CW-1:0] oy;
    logic [2:0][DW-1:0] ex;
    logic [2:0][DW-1:0] ey;
    logic [2:0]         pos;
    logic [EW-1:0]      mag;
    logic               deg;
    logic [2:0][VW-1:0] val;
  } geom_t;

  typedef struct packed {
    logic [EW-1:0]       rem;
    logic [RES_BITS-1:0] nq;
    logic                neg;
    logic                ovf;
    logic                ins;
  } div_t;

  function automatic logic [CW-1:0] sext_coord(logic [FIELD_BITS-1:0] f);
    return CW'({1'b0, f});
  endfunction

  function automatic logic [VW-1:0] sext_value(logic [FIELD_BITS-1:0] f);
    return VW'({1'b0, f});
  endfunction

endpackage

FILE: hdl/tli_setup.sv
module tli_setup import tli_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [2:0][2*FIELD_BITS-1:0] vertex_i,
  input  logic [2:0][FIELD_BITS-1:0]   value_i,
  output geom_t                        geom_o
);

  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];
  logic signed [CW-1:0] ox [3];
  logic signed [CW-1:0] oy [3];
  logic signed [CW-1:0] tx [3];
  logic signed [CW-1:0] ty [3];
  logic signed [CW-1:0] px [3];
  logic signed [CW-1:0] py [3];

  logic signed [DW-1:0] ex_q [3];
  logic signed [DW-1:0] ey_q [3];
  logic signed [DW-1:0] dx_q [3];
  logic signed [DW-1:0] dy_q [3];
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic signed [EW-1:0] den_q [3];
  logic [EW-1:0]        mag_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vx[k] = sext_coord(vertex_i[k][2*FIELD_BITS-1:FIELD_BITS]);
      vy[k] = sext_coord(vertex_i[k][FIELD_BITS-1:0]);
    end
    // origin, edge end and opposite vertex per edge function
    ox[0] = vx[1]; oy[0] = vy[1]; tx[0] = vx[2]; ty[0] = vy[2]; px[0] = vx[0]; py[0] = vy[0];
    ox[1] = vx[0]; oy[1] = vy[0]; tx[1] = vx[2]; ty[1] = vy[2]; px[1] = vx[1]; py[1] = vy[1];
    ox[2] = vx[0]; oy[2] = vy[0]; tx[2] = vx[1]; ty[2] = vy[1]; px[2] = vx[2]; py[2] = vy[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        ex_q[k]  <= '0;
        ey_q[k]  <= '0;
        dx_q[k]  <= '0;
        dy_q[k]  <= '0;
        pa_q[k]  <= '0;
        pb_q[k]  <= '0;
        den_q[k] <= '0;
      end
      mag_q <= '0;
    end else begin
      for (int k = 0; k < 3; k++) begin
        ex_q[k]  <= DW'(tx[k]) - DW'(ox[k]);
        ey_q[k]  <= DW'(ty[k]) - DW'(oy[k]);
        dx_q[k]  <= DW'(px[k]) - DW'(ox[k]);
        dy_q[k]  <= DW'(py[k]) - DW'(oy[k]);
        pa_q[k]  <= PW'(dx_q[k]) * PW'(ey_q[k]);
        pb_q[k]  <= PW'(dy_q[k]) * PW'(ex_q[k]);
        den_q[k] <= EW'(pa_q[k]) - EW'(pb_q[k]);
      end
      mag_q <= den_q[0][EW-1] ? EW'(-den_q[0]) : EW'(den_q[0]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      geom_o.ox[k]  = ox[k];
      geom_o.oy[k]  = oy[k];
      geom_o.ex[k]  = ex_q[k];
      geom_o.ey[k]  = ey_q[k];
      geom_o.pos[k] = !den_q[k][EW-1] && (den_q[k] != '0);
      geom_o.val[k] = sext_value(value_i[k]);
    end
    geom_o.mag = mag_q;
    geom_o.deg = (den_q[0] == '0) || (den_q[1] == '0) || (den_q[2] == '0);
  end

endmodule

FILE: hdl/tli_front.sv
module tli_front import tli_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  in_t   data_i,
  input  geom_t geom_i,
  output logic  valid_o,
  output div_t  data_o
);

  logic [7:0] vld_q;

  logic signed [CW-1:0] qx_q, qy_q;
  logic signed [DW-1:0] dqx_q [3];
  logic signed [DW-1:0] dqy_q [3];
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic signed [EW-1:0] w_q [3];
  logic signed [MW-1:0] m_q [3];
  logic signed [SW-1:0] s_q;
  logic [SW-1:0]        abs_q;
  logic                 ins_e_q, ins_f_q, ins_g_q;
  logic                 neg_q;
  div_t                 out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qx_q <= sext_coord(data_i.query_x);
      qy_q <= sext_coord(data_i.query_y);
      for (int k = 0; k < 3; k++) begin
        dqx_q[k] <= DW'(qx_q) - DW'($signed(geom_i.ox[k]));
        dqy_q[k] <= DW'(qy_q) - DW'($signed(geom_i.oy[k]));
        pa_q[k]  <= PW'(dqx_q[k]) * PW'($signed(geom_i.ey[k]));
        pb_q[k]  <= PW'(dqy_q[k]) * PW'($signed(geom_i.ex[k]));
        w_q[k]   <= geom_i.pos[k] ? EW'(pa_q[k]) - EW'(pb_q[k])
                                  : EW'(pb_q[k]) - EW'(pa_q[k]);
        m_q[k]   <= MW'(w_q[k]) * MW'($signed(geom_i.val[k]));
      end
      ins_e_q <= !w_q[0][EW-1] && !w_q[1][EW-1] && !w_q[2][EW-1];
      s_q     <= SW'(m_q[0]) + SW'(m_q[1]) + SW'(m_q[2]);
      ins_f_q <= ins_e_q;
      neg_q   <= s_q[SW-1];
      abs_q   <= s_q[SW-1] ? SW'(-s_q) : SW'(s_q);
      ins_g_q <= ins_f_q;
      out_q.neg <= neg_q;
      out_q.ins <= ins_g_q;
      out_q.ovf <= AW'(abs_q) >= (AW'(geom_i.mag) << HI_SHIFT);
      out_q.rem <= EW'(abs_q >> HI_SHIFT);
      out_q.nq  <= RES_BITS'(AW'(abs_q) << FRAC_BITS);
    end
  end

  assign valid_o = vld_q[7];
  assign data_o  = out_q;

endmodule

FILE: hdl/tli_div_stage.sv
module tli_div_stage import tli_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [EW-1:0] mag_i,
  input  logic          valid_i,
  input  div_t          data_i,
  output logic          valid_o,
  output div_t          data_o
);

  logic          valid_q;
  div_t          data_q;
  logic [EW:0]   trial;
  logic          ge;

  assign trial = {data_i.rem, data_i.nq[RES_BITS-1]};
  assign ge    = trial >= {1'b0, mag_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q.rem <= ge ? EW'(trial - {1'b0, mag_i}) : EW'(trial);
      data_q.nq  <= {data_i.nq[RES_BITS-2:0], ge};
      data_q.neg <= data_i.neg;
      data_q.ovf <= data_i.ovf;
      data_q.ins <= data_i.ins;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hdl/triangle_linear_interpolator_unit.sv
// throughput: one transaction per cycle while the output is not stalled;
// the pipeline is an 8-stage front end, a 32-stage restoring divider,
// one quotient bit per stage, and the output register
// the whole pipeline advances together and holds while the output stalls
// reset clears all valid bits and the vertex and value registers to zero
module triangle_linear_interpolator_unit import tli_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [RES_BITS-1:0]   cfg_data_i
);

  logic [2:0][2*FIELD_BITS-1:0] vertex_q;
  logic [2:0][FIELD_BITS-1:0]   value_q;
  geom_t                        geom;
  logic                         en;
  logic                         out_valid_q;
  out_t                         out_q;
  out_t                         out_d;

  logic        vld [RES_BITS+1];
  div_t        dat [RES_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_q <= '0;
      value_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VERTEX_A: vertex_q[0] <= cfg_data_i;
        REG_VERTEX_B: vertex_q[1] <= cfg_data_i;
        REG_VERTEX_C: vertex_q[2] <= cfg_data_i;
        REG_VALUE_A:  value_q[0]  <= cfg_data_i[FIELD_BITS-1:0];
        REG_VALUE_B:  value_q[1]  <= cfg_data_i[FIELD_BITS-1:0];
        REG_VALUE_C:  value_q[2]  <= cfg_data_i[FIELD_BITS-1:0];
        default: ;
      endcase
    end
  end

  tli_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vertex_i(vertex_q),
    .value_i (value_q),
    .geom_o  (geom)
  );

  assign en = !out_valid_q || out_ready_i;

  tli_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .data_i (in_data_i),
    .geom_i (geom),
    .valid_o(vld[0]),
    .data_o (dat[0])
  );

  for (genvar i = 0; i < RES_BITS; i++) begin : g_div
    tli_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .mag_i  (geom.mag),
      .valid_i(vld[i]),
      .data_i (dat[i]),
      .valid_o(vld[i+1]),
      .data_o (dat[i+1])
    );
  end

  always_comb begin
    div_t d;
    d = dat[RES_BITS];
    out_d.degenerate = 1'b0;
    out_d.inside_res = d.ins;
    if (geom.deg) begin
      out_d.interp_value = '0;
      out_d.inside_res   = 1'b0;
      out_d.degenerate   = 1'b1;
      out_d.saturated    = 1'b0;
    end else if (!d.neg) begin
      out_d.saturated    = d.ovf || d.nq[RES_BITS-1];
      out_d.interp_value = out_d.saturated ? {1'b0, {(RES_BITS-1){1'b1}}} : d.nq;
    end else begin
      out_d.saturated    = d.ovf || (d.nq[RES_BITS-1] && (d.nq[RES_BITS-2:0] != '0));
      out_d.interp_value = out_d.saturated ? {1'b1, {(RES_BITS-1){1'b0}}} : -d.nq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld[RES_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: test/tb_triangle_linear_interpolator_unit.sv
module tb_triangle_linear_interpolator_unit;
  import tli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 41;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [RES_BITS-1:0] cfg_data_i = '0;

  triangle_linear_interpolator_unit u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of the registers
  logic [31:0] vtx [3];
  logic signed [15:0] vval [3];
  out_t expected_q [$];
  int errors = 0;
  longint cycles = 0;
  bit idle_en = 1'b1;

  function automatic longint cross_edge(longint ax, longint ay, longint bx, longint by,
                                        longint dx, longint dy);
    return (dx - ax) * (by - ay) - (dy - ay) * (bx - ax);
  endfunction

  function automatic out_t interpolate(in_t q);
    out_t r;
    longint px [3];
    longint py [3];
    longint den [3];
    longint num [3];
    longint w, s, mag, quo, rem, lim, res;
    longint qx, qy;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      px[k] = longint'($signed(vtx[k][31:16]));
      py[k] = longint'($signed(vtx[k][15:0]));
    end
    qx = longint'(q.query_x);
    qy = longint'(q.query_y);
    den[0] = cross_edge(px[1], py[1], px[2], py[2], px[0], py[0]);
    den[1] = cross_edge(px[0], py[0], px[2], py[2], px[1], py[1]);
    den[2] = cross_edge(px[0], py[0], px[1], py[1], px[2], py[2]);
    num[0] = cross_edge(px[1], py[1], px[2], py[2], qx, qy);
    num[1] = cross_edge(px[0], py[0], px[2], py[2], qx, qy);
    num[2] = cross_edge(px[0], py[0], px[1], py[1], qx, qy);
    if (den[0] == 0 || den[1] == 0 || den[2] == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    r.inside_res = 1'b1;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      w = den[k] > 0 ? num[k] : -num[k];
      if (w < 0) r.inside_res = 1'b0;
      s += w * longint'(vval[k]);
    end
    mag = den[0] > 0 ? den[0] : -den[0];
    quo = s / mag;
    rem = s % mag;
    lim = longint'(1) << (31 - FRAC_BITS);
    if (quo > lim) begin
      res = 64'sh7FFFFFFF;
      r.saturated = 1'b1;
    end else if (quo < -lim) begin
      res = -64'sh80000000;
      r.saturated = 1'b1;
    end else begin
      res = quo * (longint'(1) << FRAC_BITS) + (rem * (longint'(1) << FRAC_BITS)) / mag;
      if (res > 64'sh7FFFFFFF) begin
        res = 64'sh7FFFFFFF;
        r.saturated = 1'b1;
      end else if (res < -64'sh80000000) begin
        res = -64'sh80000000;
        r.saturated = 1'b1;
      end
    end
    r.interp_value = res[31:0];
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_VERTEX_A: vtx[0] = data;
      REG_VERTEX_B: vtx[1] = data;
      REG_VERTEX_C: vtx[2] = data;
      REG_VALUE_A: vval[0] = data[15:0];
      REG_VALUE_B: vval[1] = data[15:0];
      REG_VALUE_C: vval[2] = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_triangle(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                              logic [15:0] va, logic [15:0] vb, logic [15:0] vc);
    write_reg(REG_VERTEX_A, a);
    write_reg(REG_VERTEX_B, b);
    write_reg(REG_VERTEX_C, c);
    write_reg(REG_VALUE_A, {16'h0, va});
    write_reg(REG_VALUE_B, {16'h0, vb});
    write_reg(REG_VALUE_C, {16'h0, vc});
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic send_point(logic [15:0] x, logic [15:0] y);
    in_t d;
    d.query_x = x;
    d.query_y = y;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(interpolate(d));
  endtask

  // near-vertex coordinates keep points around the triangle
  function automatic logic [15:0] near_coord(logic [15:0] c);
    return c + 16'($signed($urandom_range(0, 80)) - 40);
  endfunction

  task automatic test_reset_degenerate();
    vtx = '{default: '0};
    vval = '{default: '0};
    send_point(16'h0000, 16'h0000);
    send_point(16'h7FFF, 16'h8000);
    drain();
  endtask

  task automatic test_directed();
    set_triangle({16'd0, 16'd0}, {16'd100, 16'd0}, {16'd0, 16'd100},
                 16'd1000, 16'hFC18, 16'd7);
    send_point(16'd0, 16'd0);
    send_point(16'd100, 16'd0);
    send_point(16'd0, 16'd100);
    send_point(16'd50, 16'd50);
    send_point(16'd33, 16'd33);
    send_point(16'd51, 16'd50);
    send_point(16'hFFFF, 16'd3);
    send_point(16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000);
    send_point(16'h8000, 16'h7FFF);
    send_point(16'hAAAA, 16'h5555);
    drain();
    // extreme vertices and values, drives saturation
    set_triangle({16'h8000, 16'h8000}, {16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF},
                 16'h7FFF, 16'h8000, 16'h7FFF);
    send_point(16'h7FFF, 16'h7FFF);
    send_point(16'h0000, 16'h0000);
    send_point(16'h8000, 16'h8000);
    drain();
    set_triangle({16'd0, 16'd0}, {16'd1, 16'd0}, {16'd0, 16'd1},
                 16'h7FFF, 16'h8000, 16'h7FFF);
    send_point(16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h7FFF);
    send_point(16'h7FFF, 16'h8000);
    send_point(16'd1, 16'd0);
    drain();
    // collinear vertices
    set_triangle({16'd1, 16'd1}, {16'd2, 16'd2}, {16'd5, 16'd5},
                 16'd3, 16'd4, 16'd5);
    send_point(16'd2, 16'd2);
    drain();
  endtask

  task automatic test_random(int n_sets, int per_set);
    logic [31:0] a, b, c;
    for (int s = 0; s < n_sets; s++) begin
      a = $urandom;
      if ($urandom_range(0, 3) != 0) begin
        a = {16'($signed($urandom_range(0, 400)) - 200),
             16'($signed($urandom_range(0, 400)) - 200)};
        b = {a[31:16] + 16'($urandom_range(1, 300)), a[15:0] + 16'($urandom_range(0, 50))};
        c = {a[31:16] + 16'($urandom_range(0, 50)), a[15:0] + 16'($urandom_range(1, 300))};
      end else begin
        b = $urandom;
        c = $urandom;
      end
      set_triangle(a, b, c, 16'($urandom), 16'($urandom), 16'($urandom));
      for (int i = 0; i < per_set; i++) begin
        if ($urandom_range(0, 3) == 0) send_point(16'($urandom), 16'($urandom));
        else if ($urandom_range(0, 1) == 0) send_point(near_coord(a[31:16]), near_coord(a[15:0]));
        else send_point(near_coord(b[31:16]), near_coord(c[15:0]));
      end
      drain();
    end
  endtask

  // result checker and sink stall
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: %p", out_data_o);
      end else begin
        out_t e;
        e = expected_q.pop_front();
        if (out_data_o !== e) begin
          errors++;
          if (errors <= 10) $display("mismatch: exp %p act %p", e, out_data_o);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!idle_en) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    vtx = '{default: '0};
    vval = '{default: '0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_degenerate();
    test_directed();
    test_random(25, 40);
    idle_en = 1'b0;
    test_random(10, 50);
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hdl/tli_pkg.sv
hdl/tli_setup.sv
hdl/tli_front.sv
hdl/tli_div_stage.sv
hdl/triangle_linear_interpolator_unit.sv
test/tb_triangle_linear_interpolator_unit.sv
